### src/session_table_match_unit_defines.svh
// -----------------------------------------------------------------------------
// Session table match unit: assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef SESSION_TABLE_MATCH_UNIT_DEFINES_SVH
`define SESSION_TABLE_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define STM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/stm_pkg.sv
// -----------------------------------------------------------------------------
// Session table match package
// Request, response and cell-to-cell beat types, table size and codes.
// -----------------------------------------------------------------------------
package stm_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned SlotW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  typedef enum logic [1:0] {
    ReqInsert      = 2'd0,
    ReqLookupId    = 2'd1,
    ReqLookupTuple = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] session_id;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [63:0] found_id;
    logic [15:0] found_source_port;
    logic [15:0] found_dest_port;
    logic [7:0]  found_protocol;
  } rsp_t;

  // Request walking down the chain, with the best hit (or placement) so far.
  typedef struct packed {
    logic             vld;
    req_t             req;
    logic             done;
    logic [SlotW-1:0] rslot;
    logic [63:0]      rid;
    logic [15:0]      rsp;
    logic [15:0]      rdp;
    logic [7:0]       rpr;
  } beat_t;

endpackage

### src/session_table_match_unit.sv
// Path: an accepted request passes the TableDepth cell registers in order,
// then the output register; a stalled output holds the whole chain.
// Throughput: one request in flight; a new one is taken once the previous
// beat has left the last cell and the output is not stalled.
// Reset (async, active low) empties the table and drops any beat in flight.
// -----------------------------------------------------------------------------
// Session table match unit
// Bounded session table built as a chain of cells; inserts fill the first
// free cell, lookups keep the hit from the newest (highest) matching cell.
// -----------------------------------------------------------------------------
module session_table_match_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stm_pkg::rsp_t out_data_o
);
  import stm_pkg::*;

`include "session_table_match_unit_defines.svh"

  beat_t                 beats [TableDepth+1];
  logic [TableDepth-1:0] occ;
  logic [TableDepth-1:0] bvld;
  logic                  adv;
  logic                  busy_q;
  logic                  out_valid_q;
  rsp_t                  out_q;
  rsp_t                  out_d;
  beat_t                 last;

  // hold the chain while a finished result waits at the output
  assign adv        = !out_valid_q || out_ready_i;
  // take a beat only when the first cell can capture it
  assign in_ready_o = !busy_q && adv;

  always_comb begin
    beats[0]     = '0;
    beats[0].vld = in_valid_i && in_ready_o;
    beats[0].req = in_data_i;
  end

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    stm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .slot_idx_i (SlotW'(i)),
      .beat_i     (beats[i]),
      .beat_o     (beats[i+1]),
      .occ_o      (occ[i])
    );
    assign bvld[i] = beats[i+1].vld;
  end

  assign last = beats[TableDepth];

  always_comb begin
    out_d                   = '0;
    out_d.slot              = 4'(last.rslot);
    out_d.found_id          = last.rid;
    out_d.found_source_port = last.rsp;
    out_d.found_dest_port   = last.rdp;
    out_d.found_protocol    = last.rpr;
    if (last.done) begin
      out_d.status = StOk;
    end else begin
      out_d = '0;
      if (last.req.req_type == ReqInsert) begin
        out_d.status = StFull;
      end else begin
        out_d.status = StMiss;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
      end else if (last.vld && adv) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= last.vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.vld && adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `STM_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, busy_q && bvld[0],
                   "accepted beat did not enter the chain")
  `STM_ASSERT_IMPL(a_single_beat, 1'b1, $countones(bvld) <= 1,
                   "more than one beat in the chain")
  `STM_ASSERT_IMPL(a_occ_thermo, 1'b1, (occ & (occ + TableDepth'(1))) == '0,
                   "occupied cells are not a contiguous low range")
  `STM_ASSERT_IMPL(a_full_only, last.vld && adv && out_d.status == StFull, &occ,
                   "table full reported with a free cell")

endmodule

### src/stm_cell.sv
// -----------------------------------------------------------------------------
// Session table cell
// Holds one table entry and its occupied flag; checks the passing beat
// against it and hands it on through a beat register that holds while adv_i is low.
// -----------------------------------------------------------------------------
module stm_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic [stm_pkg::SlotW-1:0] slot_idx_i,
  input  stm_pkg::beat_t           beat_i,
  output stm_pkg::beat_t           beat_o,
  output logic                     occ_o
);
  import stm_pkg::*;

  logic        occ_q;
  logic [63:0] id_q;
  logic [15:0] sp_q;
  logic [15:0] dp_q;
  logic [7:0]  pr_q;
  beat_t       beat_q;
  beat_t       beat_d;
  logic        wr_en;

  always_comb begin
    beat_d = beat_i;
    wr_en  = 1'b0;
    if (beat_i.vld) begin
      case (beat_i.req.req_type)
        ReqInsert: begin
          // first free cell takes the entry
          if (!occ_q && !beat_i.done) begin
            wr_en        = 1'b1;
            beat_d.done  = 1'b1;
            beat_d.rslot = slot_idx_i;
            beat_d.rid   = beat_i.req.session_id;
            beat_d.rsp   = beat_i.req.source_port;
            beat_d.rdp   = beat_i.req.dest_port;
            beat_d.rpr   = beat_i.req.protocol;
          end
        end
        ReqLookupId: begin
          // later cells are newer, so overwrite any earlier hit
          if (occ_q && (id_q == beat_i.req.session_id)) begin
            beat_d.done  = 1'b1;
            beat_d.rslot = slot_idx_i;
            beat_d.rid   = id_q;
            beat_d.rsp   = sp_q;
            beat_d.rdp   = dp_q;
            beat_d.rpr   = pr_q;
          end
        end
        ReqLookupTuple: begin
          if (occ_q && (sp_q == beat_i.req.source_port) &&
              (dp_q == beat_i.req.dest_port) && (pr_q == beat_i.req.protocol)) begin
            beat_d.done  = 1'b1;
            beat_d.rslot = slot_idx_i;
            beat_d.rid   = id_q;
            beat_d.rsp   = sp_q;
            beat_d.rdp   = dp_q;
            beat_d.rpr   = pr_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      beat_q <= '0;
    end else if (adv_i) begin
      beat_q <= beat_d;
      if (wr_en) begin
        occ_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr_en) begin
      id_q <= beat_i.req.session_id;
      sp_q <= beat_i.req.source_port;
      dp_q <= beat_i.req.dest_port;
      pr_q <= beat_i.req.protocol;
    end
  end

  assign beat_o = beat_q;
  assign occ_o  = occ_q;

endmodule

### verif/session_table_match_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Session table match unit testbench
// Drives insert, id lookup and tuple lookup beats into the unit. Random idle
// cycles fall on both handshakes. A local mirror of the table predicts every
// response, and a checker compares each output beat field by field in order.
// -----------------------------------------------------------------------------
module session_table_match_unit_tb;
  import stm_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned IdlePct  = 37;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  // Mirror of the table contents.
  logic [63:0] mirror_id    [TableDepth];
  logic [15:0] mirror_sport [TableDepth];
  logic [15:0] mirror_dport [TableDepth];
  logic [7:0]  mirror_proto [TableDepth];
  int          mirror_count = 0;

  rsp_t pending_rsp_q[$];
  bit   quiet = 1'b0;
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_insert = 0;
  int   n_full = 0;
  int   n_hit = 0;
  int   n_miss = 0;

  session_table_match_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk_i = ~clk_i;

  // Work out the response to one request and update the mirror.
  function automatic rsp_t predict_session_rsp(input req_t r);
    rsp_t rsp;
    bit   hit;
    rsp = '0;
    rsp.status = StMiss;
    hit = 1'b0;
    if (r.req_type == ReqInsert) begin
      n_insert++;
      if (mirror_count >= TableDepth) begin
        rsp.status = StFull;
        n_full++;
      end else begin
        mirror_id[mirror_count]    = r.session_id;
        mirror_sport[mirror_count] = r.source_port;
        mirror_dport[mirror_count] = r.dest_port;
        mirror_proto[mirror_count] = r.protocol;
        rsp.status            = StOk;
        rsp.slot              = 4'(mirror_count);
        rsp.found_id          = r.session_id;
        rsp.found_source_port = r.source_port;
        rsp.found_dest_port   = r.dest_port;
        rsp.found_protocol    = r.protocol;
        mirror_count++;
      end
    end else if (r.req_type == ReqLookupId || r.req_type == ReqLookupTuple) begin
      // newest entry sits in the highest occupied slot
      for (int i = mirror_count - 1; i >= 0 && !hit; i--) begin
        if (r.req_type == ReqLookupId)
          hit = (mirror_id[i] == r.session_id);
        else
          hit = (mirror_sport[i] == r.source_port && mirror_dport[i] == r.dest_port &&
                 mirror_proto[i] == r.protocol);
        if (hit) begin
          rsp.status            = StOk;
          rsp.slot              = 4'(i);
          rsp.found_id          = mirror_id[i];
          rsp.found_source_port = mirror_sport[i];
          rsp.found_dest_port   = mirror_dport[i];
          rsp.found_protocol    = mirror_proto[i];
        end
      end
      if (hit) n_hit++;
      else n_miss++;
    end else begin
      n_miss++;
    end
    return rsp;
  endfunction

  function automatic req_t make_req(input logic [1:0] kind, input logic [63:0] id,
                                    input logic [15:0] sport, input logic [15:0] dport,
                                    input logic [7:0] proto);
    req_t r;
    r.req_type    = kind;
    r.session_id  = id;
    r.source_port = sport;
    r.dest_port   = dport;
    r.protocol    = proto;
    return r;
  endfunction

  function automatic req_t rand_req(input logic [1:0] kind);
    return make_req(kind, {$urandom(), $urandom()}, 16'($urandom()), 16'($urandom()),
                    8'($urandom()));
  endfunction

  // Mostly lookups of stored keys, some near misses, a few inserts and junk codes.
  function automatic req_t rand_traffic_req();
    req_t        r;
    int unsigned pick;
    int unsigned s;
    int unsigned f;
    r    = rand_req(ReqInsert);
    pick = $urandom_range(99);
    s    = (mirror_count > 0) ? $urandom_range(mirror_count - 1) : 0;
    if (pick < 8) begin
      // reuse a stored key now and then to build shadowed duplicates
      if (mirror_count > 0 && $urandom_range(3) == 0) begin
        if ($urandom_range(1) == 0) begin
          r.session_id = mirror_id[s];
        end else begin
          r.source_port = mirror_sport[s];
          r.dest_port   = mirror_dport[s];
          r.protocol    = mirror_proto[s];
        end
      end
    end else if (pick < 52) begin
      r.req_type = ReqLookupId;
      if (mirror_count > 0 && $urandom_range(9) < 7) begin
        r.session_id = mirror_id[s];
        if ($urandom_range(4) == 0) r.session_id[$urandom_range(63)] ^= 1'b1;
      end
    end else if (pick < 95) begin
      r.req_type = ReqLookupTuple;
      if (mirror_count > 0 && $urandom_range(9) < 7) begin
        r.source_port = mirror_sport[s];
        r.dest_port   = mirror_dport[s];
        r.protocol    = mirror_proto[s];
        if ($urandom_range(4) == 0) begin
          f = $urandom_range(2);
          if (f == 0) r.source_port[$urandom_range(15)] ^= 1'b1;
          else if (f == 1) r.dest_port[$urandom_range(15)] ^= 1'b1;
          else r.protocol[$urandom_range(7)] ^= 1'b1;
        end
      end
    end else begin
      r.req_type = ReqUnused;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // Send one request beat; hold valid until it is taken.
  task automatic send_req(input req_t r);
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready);
    pending_rsp_q.push_back(predict_session_rsp(r));
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    out_ready <= quiet || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data.found_id, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.slot !== want.slot)
          report_mismatch("slot", out_data.slot, want.slot);
        if (out_data.found_id !== want.found_id)
          report_mismatch("found_id", out_data.found_id, want.found_id);
        if (out_data.found_source_port !== want.found_source_port)
          report_mismatch("found_source_port", out_data.found_source_port,
                          want.found_source_port);
        if (out_data.found_dest_port !== want.found_dest_port)
          report_mismatch("found_dest_port", out_data.found_dest_port,
                          want.found_dest_port);
        if (out_data.found_protocol !== want.found_protocol)
          report_mismatch("found_protocol", out_data.found_protocol, want.found_protocol);
      end
    end
  end

  task automatic test_empty_table();
    send_req(make_req(ReqLookupId, '0, '0, '0, '0));
    send_req(make_req(ReqLookupId, '1, '1, '1, '1));
    send_req(make_req(ReqLookupTuple, '0, '0, '0, '0));
    send_req(make_req(ReqLookupTuple, '1, '1, '1, '1));
    send_req(make_req(ReqUnused, '1, '1, '1, '1));
  endtask

  task automatic test_insert_and_shadow();
    send_req(make_req(ReqInsert, '1, '1, '1, '1));
    send_req(make_req(ReqInsert, '0, '0, '0, '0));
    send_req(rand_req(ReqInsert));
    send_req(make_req(ReqLookupId, '1, '0, '0, '0));
    send_req(make_req(ReqLookupId, '0, '1, '1, '1));
    // ids that differ from a stored one only in the top or bottom bit
    send_req(make_req(ReqLookupId, 64'h7fff_ffff_ffff_ffff, '0, '0, '0));
    send_req(make_req(ReqLookupId, 64'hffff_ffff_ffff_fffe, '0, '0, '0));
    send_req(make_req(ReqLookupTuple, '0, '1, '1, '1));
    send_req(make_req(ReqLookupTuple, '0, '1, '1, 8'hfe));
    // duplicate id: the newer entry must shadow the older one
    send_req(make_req(ReqInsert, '1, 16'h1234, 16'h5678, 8'h11));
    send_req(make_req(ReqLookupId, '1, '0, '0, '0));
    // duplicate tuple with a new id
    send_req(make_req(ReqInsert, 64'h0123_4567_89ab_cdef, '0, '0, '0));
    send_req(make_req(ReqLookupTuple, '1, '0, '0, '0));
    send_req(make_req(ReqUnused, '1, '0, '0, '0));
    send_req(make_req(ReqLookupTuple, '0, 16'h0001, '0, '0));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_req(rand_traffic_req());
  endtask

  task automatic test_back_to_back(input int count);
    quiet = 1'b1;
    repeat (count) send_req(rand_traffic_req());
    quiet = 1'b0;
  endtask

  task automatic test_full_table();
    req_t rejected;
    while (mirror_count < TableDepth) send_req(rand_req(ReqInsert));
    rejected = rand_req(ReqInsert);
    send_req(make_req(ReqInsert, '1, '1, '1, '1));
    send_req(make_req(ReqInsert, '0, '0, '0, '0));
    send_req(rejected);
    rejected.req_type = ReqLookupId;
    send_req(rejected);
    rejected.req_type = ReqLookupTuple;
    send_req(rejected);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_insert_and_shadow();
    test_random_traffic(300);
    test_back_to_back(40);
    test_random_traffic(320);
    test_full_table();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 4) @(posedge clk_i);
    $display("Run covered %0d requests: %0d inserts (%0d refused on a full table),",
             n_sent, n_insert, n_full);
    $display("%0d lookup hits and %0d misses or unused codes.", n_hit, n_miss);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d responses outstanding", pending_rsp_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
